### src/boc_pkg.sv
// ----------------------------------------------------------------------------
// boc_pkg
// Types, constants and a helper function for the occupancy cell update.
// ----------------------------------------------------------------------------
package boc_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int HISTORY   = 8;
	localparam int NUM_CELLS = (HISTORY < NUM_SLOTS) ? HISTORY : NUM_SLOTS;

	localparam int READ_W = 13;
	localparam int PROB_W = 16;
	localparam int LIK_W  = 17;
	localparam int CFG_W  = 17;
	localparam int SUM_W  = 34;

	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = PROB_W / DIV_STEPS;
	localparam int CELL_LAT   = DIV_STAGES + 5;

	localparam logic [PROB_W-1:0] MAX_OCC_LIK = 16'd64881;
	localparam logic [LIK_W-1:0]  MIN_EMP_LIK = 17'd655;
	localparam logic [LIK_W-1:0]  ONE_Q16     = 17'h10000;
	localparam logic [PROB_W-1:0] PROB_MAX    = 16'hFFFF;

	typedef enum logic [2:0] {
		CFG_PRIOR     = 3'd0,
		CFG_EMP_OCC   = 3'd1,
		CFG_EMP_EMP   = 3'd2,
		CFG_OCC_RATE  = 3'd3,
		CFG_OCC_OFF   = 3'd4,
		CFG_EMP_RATE  = 3'd5,
		CFG_EMP_OFF   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [PROB_W-1:0]        prior_prob;
		logic [PROB_W-1:0]        empty_given_occupied;
		logic [PROB_W-1:0]        empty_given_empty;
		logic signed [CFG_W-1:0]  hit_occ_rate;
		logic signed [CFG_W-1:0]  hit_occ_offset;
		logic signed [CFG_W-1:0]  hit_emp_rate;
		logic signed [CFG_W-1:0]  hit_emp_offset;
	} cfg_t;

	typedef logic [NUM_SLOTS-1:0][READ_W-1:0] readings_t;

	typedef struct packed {
		logic [PROB_W-1:0] p;
		logic              degen;
		readings_t         rd;
	} tok_t;

	typedef struct packed {
		logic [SUM_W-1:0]  rem;
		logic [SUM_W-1:0]  sum;
		logic [PROB_W-1:0] quo;
		logic              skip;
		logic              zero;
		logic              full;
	} div_t;

	// Two restoring long-division steps on a remainder kept below the divisor.
	function automatic div_t div_step(input div_t d);
		div_t          o;
		logic [SUM_W:0] r2;
		o = d;
		for (int j = 0; j < DIV_STEPS; j++) begin
			r2 = {o.rem, 1'b0};
			if (r2 >= {1'b0, o.sum}) begin
				r2    = r2 - {1'b0, o.sum};
				o.quo = {o.quo[PROB_W-2:0], 1'b1};
			end else begin
				o.quo = {o.quo[PROB_W-2:0], 1'b0};
			end
			o.rem = r2[SUM_W-1:0];
		end
		return o;
	endfunction

endpackage

### src/boc_if.sv
// ----------------------------------------------------------------------------
// boc_if
// Valid/ready channels for the readings and the posterior.
// ----------------------------------------------------------------------------
interface boc_in_if;
	logic        valid;
	logic        ready;
	logic [12:0] reading_0;
	logic [12:0] reading_1;
	logic [12:0] reading_2;
	logic [12:0] reading_3;
	logic [12:0] reading_4;
	logic [12:0] reading_5;
	logic [12:0] reading_6;
	logic [12:0] reading_7;

	modport source (output valid, reading_0, reading_1, reading_2, reading_3,
		reading_4, reading_5, reading_6, reading_7, input ready);
	modport sink (input valid, reading_0, reading_1, reading_2, reading_3,
		reading_4, reading_5, reading_6, reading_7, output ready);
endinterface

interface boc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] occupancy_prob;
	logic        degenerate;

	modport source (output valid, occupancy_prob, degenerate, input ready);
	modport sink (input valid, occupancy_prob, degenerate, output ready);
endinterface

### src/bayes_occupancy_cell_update.sv
// ----------------------------------------------------------------------------
// bayes_occupancy_cell_update
// Posterior occupancy of one grid cell from its slot history of hit counts.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  cell_in    sink       reading_0 .. reading_7
//  cell_out   source     occupancy_prob, degenerate
//  cfg_*      write      seven likelihood and prior registers
//
// One beat is accepted per cycle while the output beat is not stalled. Each
// slot has its own cell of 13 stages, set by the 16-bit quotient taken two
// bits a stage. The chain shares one stall: it holds while the output beat
// waits. Reset clears valid state and loads the register defaults.
module bayes_occupancy_cell_update import boc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	boc_in_if.sink           cell_in,
	boc_out_if.source        cell_out
);

	cfg_t cfg_q;
	logic en;
	logic vld_c [NUM_CELLS+1];
	tok_t tok_c [NUM_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prior_prob           <= 16'd32768;
			cfg_q.empty_given_occupied <= 16'd13107;
			cfg_q.empty_given_empty    <= 16'd52429;
			cfg_q.hit_occ_rate         <= 17'sd3277;
			cfg_q.hit_occ_offset       <= 17'sd32768;
			cfg_q.hit_emp_rate         <= -17'sd6554;
			cfg_q.hit_emp_offset       <= 17'sd19661;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PRIOR:    cfg_q.prior_prob           <= cfg_wdata[PROB_W-1:0];
				CFG_EMP_OCC:  cfg_q.empty_given_occupied <= cfg_wdata[PROB_W-1:0];
				CFG_EMP_EMP:  cfg_q.empty_given_empty    <= cfg_wdata[PROB_W-1:0];
				CFG_OCC_RATE: cfg_q.hit_occ_rate         <= $signed(cfg_wdata);
				CFG_OCC_OFF:  cfg_q.hit_occ_offset       <= $signed(cfg_wdata);
				CFG_EMP_RATE: cfg_q.hit_emp_rate         <= $signed(cfg_wdata);
				CFG_EMP_OFF:  cfg_q.hit_emp_offset       <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	assign en            = !vld_c[NUM_CELLS] || cell_out.ready;
	assign cell_in.ready = en;

	always_comb begin
		vld_c[0]       = cell_in.valid;
		tok_c[0].p     = cfg_q.prior_prob;
		tok_c[0].degen = 1'b0;
		tok_c[0].rd    = {cell_in.reading_7, cell_in.reading_6, cell_in.reading_5,
			cell_in.reading_4, cell_in.reading_3, cell_in.reading_2,
			cell_in.reading_1, cell_in.reading_0};
	end

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		boc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cfg    (cfg_q),
			.vld_i  (vld_c[c]),
			.tok_i  (tok_c[c]),
			.vld_o  (vld_c[c+1]),
			.tok_o  (tok_c[c+1])
		);
	end

	assign cell_out.valid          = vld_c[NUM_CELLS];
	assign cell_out.occupancy_prob = tok_c[NUM_CELLS].p;
	assign cell_out.degenerate     = tok_c[NUM_CELLS].degen;

endmodule

### src/boc_cell.sv
// ----------------------------------------------------------------------------
// boc_cell
// One Bayes update for the first reading of the beat unless it is negative,
// then hands the beat on with its readings shifted down by one slot.
// ----------------------------------------------------------------------------
module boc_cell import boc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cfg_t cfg,
	input  logic vld_i,
	input  tok_t tok_i,
	output logic vld_o,
	output tok_t tok_o
);

	logic                    vld_s1, vld_s2, vld_s3;
	tok_t                    tok_s1, tok_s2, tok_s3;
	logic signed [29:0]      po_s1, pe_s1;
	logic                    neg_s1, zero_s1;
	logic [PROB_W-1:0]       lo_s2;
	logic [LIK_W-1:0]        le_s2;
	logic                    skip_s2, skip_s3;
	logic [31:0]             bo_s3;
	logic [32:0]             be_s3;
	logic                    vld_sd [DIV_STAGES+1];
	tok_t                    tok_sd [DIV_STAGES+1];
	div_t                    div_sd [DIV_STAGES+1];

	logic signed [READ_W-1:0] n;
	logic signed [30:0]       xo, xe;
	logic [PROB_W-1:0]        lo_c;
	logic [LIK_W-1:0]         le_c;
	logic [SUM_W-1:0]         sum_c;
	div_t                     div_c;
	div_t                     dl;
	logic [SUM_W:0]           t_c;
	logic [PROB_W:0]          q_c;
	logic [PROB_W-1:0]        qs_c;
	tok_t                     tok_c;

	assign n = $signed(tok_i.rd[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1  <= tok_i;
			po_s1   <= 30'(n) * 30'(cfg.hit_occ_rate);
			pe_s1   <= 30'(n) * 30'(cfg.hit_emp_rate);
			neg_s1  <= n[READ_W-1];
			zero_s1 <= (n == '0);
		end
	end

	always_comb begin
		xo = 31'(po_s1) + 31'(cfg.hit_occ_offset);
		xe = 31'(pe_s1) + 31'(cfg.hit_emp_offset);
		if (zero_s1) begin
			lo_c = cfg.empty_given_occupied;
			le_c = {1'b0, cfg.empty_given_empty};
		end else begin
			if (xo < 0)
				lo_c = '0;
			else if (xo > $signed({15'd0, MAX_OCC_LIK}))
				lo_c = MAX_OCC_LIK;
			else
				lo_c = xo[PROB_W-1:0];
			if (xe < $signed({14'd0, MIN_EMP_LIK}))
				le_c = MIN_EMP_LIK;
			else if (xe > $signed({14'd0, ONE_Q16}))
				le_c = ONE_Q16;
			else
				le_c = xe[LIK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s2  <= tok_s1;
			lo_s2   <= lo_c;
			le_s2   <= le_c;
			skip_s2 <= neg_s1;
			tok_s3  <= tok_s2;
			skip_s3 <= skip_s2;
			bo_s3   <= {16'd0, lo_s2} * {16'd0, tok_s2.p};
			be_s3   <= {16'd0, le_s2} * {16'd0, ONE_Q16 - {1'b0, tok_s2.p}};
		end
	end

	always_comb begin
		sum_c      = {2'b00, bo_s3} + {1'b0, be_s3};
		div_c.rem  = {2'b00, bo_s3};
		div_c.sum  = sum_c;
		div_c.quo  = '0;
		div_c.zero = !skip_s3 && (sum_c == '0);
		div_c.skip = skip_s3 || (sum_c == '0);
		div_c.full = (be_s3 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_sd[0] <= tok_s3;
			div_sd[0] <= div_c;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tok_sd[k+1] <= tok_sd[k];
				div_sd[k+1] <= div_step(div_sd[k]);
			end
		end
	end

	always_comb begin
		dl  = div_sd[DIV_STAGES];
		t_c = {1'b0, dl.rem} + {2'b00, dl.sum[SUM_W-1:1]};
		q_c = {1'b0, dl.quo} + {{PROB_W{1'b0}}, (t_c >= {1'b0, dl.sum})};
		if (dl.full || q_c[PROB_W])
			qs_c = PROB_MAX;
		else
			qs_c = q_c[PROB_W-1:0];
		tok_c       = tok_sd[DIV_STAGES];
		tok_c.p     = dl.skip ? tok_sd[DIV_STAGES].p : qs_c;
		tok_c.degen = tok_sd[DIV_STAGES].degen | dl.zero;
		tok_c.rd    = {{READ_W{1'b1}}, tok_sd[DIV_STAGES].rd[NUM_SLOTS-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_sd[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_o <= tok_c;
		end
	end

endmodule

### src/boc_checker.sv
// ----------------------------------------------------------------------------
// boc_checker
// Port-level checks on the occupancy cell update, bound to the top level.
// ----------------------------------------------------------------------------
module boc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_prob,
	input logic        out_degen
);

	// A stalled output beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_prob) && $stable(out_degen))
		else $error("output beat changed while stalled");

	// The input side takes a beat exactly when the output side is not blocked.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output stall");

	// A new output beat only appears after the chain has advanced.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("output beat appeared during a stall");

endmodule

bind bayes_occupancy_cell_update boc_checker u_boc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (cell_in.ready),
	.out_valid (cell_out.valid),
	.out_ready (cell_out.ready),
	.out_prob  (cell_out.occupancy_prob),
	.out_degen (cell_out.degenerate)
);

### verif/boc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boc_scoreboard
// Watches the register port and both channels of the occupancy cell update,
// predicts the posterior of every accepted cell and compares each output beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module boc_scoreboard import boc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	boc_in_if                cell_in,
	boc_out_if               cell_out,
	output int               mismatches,
	output int               pending
);

	typedef struct {
		logic [PROB_W-1:0] prob;
		logic              degen;
	} posterior_t;

	logic [PROB_W-1:0]       prior_q, emp_occ_q, emp_emp_q;
	logic signed [CFG_W-1:0] occ_rate_q, occ_off_q, emp_rate_q, emp_off_q;
	posterior_t              expected_q[$];

	function automatic longint clip(longint x, longint lo, longint hi);
		if (x < lo) x = lo;
		if (x > hi) x = hi;
		return x;
	endfunction

	function automatic posterior_t bayes_posterior(readings_t rd);
		posterior_t       res;
		longint unsigned  p, lo, le, bo, be, s, q;
		longint           n;
		p = prior_q;
		res.degen = 1'b0;
		for (int i = 0; i < NUM_SLOTS && i < HISTORY; i++) begin
			n = longint'($signed(rd[i]));
			if (n < 0) continue;
			if (n == 0) begin
				lo = emp_occ_q;
				le = emp_emp_q;
			end else begin
				lo = clip(n * longint'(occ_rate_q) + longint'(occ_off_q), 0, 64881);
				le = clip(n * longint'(emp_rate_q) + longint'(emp_off_q), 655, 65536);
			end
			bo = lo * p;
			be = le * (65536 - p);
			s = bo + be;
			if (s == 0) begin
				res.degen = 1'b1;
				continue;
			end
			q = (bo * 65536 + s / 2) / s;
			p = (q > 65535) ? 65535 : q;
		end
		res.prob = p[PROB_W-1:0];
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		readings_t  rd;
		posterior_t exp_v;
		if (!arst_n) begin
			prior_q    <= 16'd32768;
			emp_occ_q  <= 16'd13107;
			emp_emp_q  <= 16'd52429;
			occ_rate_q <= 17'sd3277;
			occ_off_q  <= 17'sd32768;
			emp_rate_q <= -17'sd6554;
			emp_off_q  <= 17'sd19661;
			mismatches <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PRIOR:    prior_q    <= cfg_wdata[PROB_W-1:0];
					CFG_EMP_OCC:  emp_occ_q  <= cfg_wdata[PROB_W-1:0];
					CFG_EMP_EMP:  emp_emp_q  <= cfg_wdata[PROB_W-1:0];
					CFG_OCC_RATE: occ_rate_q <= cfg_wdata;
					CFG_OCC_OFF:  occ_off_q  <= cfg_wdata;
					CFG_EMP_RATE: emp_rate_q <= cfg_wdata;
					CFG_EMP_OFF:  emp_off_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (cell_in.valid && cell_in.ready) begin
				rd = {cell_in.reading_7, cell_in.reading_6, cell_in.reading_5,
					cell_in.reading_4, cell_in.reading_3, cell_in.reading_2,
					cell_in.reading_1, cell_in.reading_0};
				expected_q.insert(expected_q.size(), bayes_posterior(rd));
			end
			if (cell_out.valid && cell_out.ready) begin
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: output beat with no cell pending", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					exp_v = expected_q.pop_front();
					if (cell_out.occupancy_prob !== exp_v.prob ||
							cell_out.degenerate !== exp_v.degen) begin
						if (mismatches < 10)
							$display("%0t: prob exp %0d got %0d, degenerate exp %0b got %0b",
								$realtime, exp_v.prob, cell_out.occupancy_prob,
								exp_v.degen, cell_out.degenerate);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cells of hit-count readings and register settings into the occupancy
// cell update with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top import boc_pkg::*;;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int               mismatches, pending;
	bit               gaps_on = 1'b1;
	bit               hold_off = 1'b0;
	bit               done = 1'b0;
	int               quiet_cycles = 0;

	boc_in_if  cell_in();
	boc_out_if cell_out();

	bayes_occupancy_cell_update uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .cell_in(cell_in), .cell_out(cell_out)
	);

	boc_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .cell_in(cell_in), .cell_out(cell_out),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		cell_in.valid = 1'b0;
		{cell_in.reading_0, cell_in.reading_1, cell_in.reading_2, cell_in.reading_3} = '0;
		{cell_in.reading_4, cell_in.reading_5, cell_in.reading_6, cell_in.reading_7} = '0;
		cell_out.ready = 1'b0;
	end

	// Output stalls, with one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				cell_out.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			cell_out.ready <= !(gaps_on && $urandom_range(99) < 27);
		end
	end

	always @(posedge clk) begin
		if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000 && !done) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [READ_W-1:0] rand_reading();
		int k;
		k = $urandom_range(99);
		if (k < 15) return '1;
		if (k < 20) return 13'h1000 | 13'($urandom);
		if (k < 35) return '0;
		if (k < 80) return 13'($urandom_range(40, 1));
		return 13'($urandom_range(4095));
	endfunction

	task automatic send_cell(readings_t rd);
		cell_in.valid     <= 1'b1;
		cell_in.reading_0 <= rd[0];
		cell_in.reading_1 <= rd[1];
		cell_in.reading_2 <= rd[2];
		cell_in.reading_3 <= rd[3];
		cell_in.reading_4 <= rd[4];
		cell_in.reading_5 <= rd[5];
		cell_in.reading_6 <= rd[6];
		cell_in.reading_7 <= rd[7];
		do @(posedge clk); while (!cell_in.ready);
		if (gaps_on && $urandom_range(99) < 27) begin
			cell_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
	endtask

	task automatic send_random(int count);
		readings_t rd;
		for (int i = 0; i < count; i++) begin
			foreach (rd[s]) rd[s] = rand_reading();
			send_cell(rd);
		end
	endtask

	task automatic drain();
		cell_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (CELL_LAT * NUM_CELLS + 16) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic write_all(logic [CFG_W-1:0] pr, logic [CFG_W-1:0] eo,
			logic [CFG_W-1:0] ee, logic [CFG_W-1:0] orate, logic [CFG_W-1:0] ooff,
			logic [CFG_W-1:0] erate, logic [CFG_W-1:0] eoff);
		write_reg(CFG_PRIOR, pr);
		write_reg(CFG_EMP_OCC, eo);
		write_reg(CFG_EMP_EMP, ee);
		write_reg(CFG_OCC_RATE, orate);
		write_reg(CFG_OCC_OFF, ooff);
		write_reg(CFG_EMP_RATE, erate);
		write_reg(CFG_EMP_OFF, eoff);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] rand_slope();
		if ($urandom_range(3) == 0) return CFG_W'($urandom);
		return CFG_W'($urandom_range(16383) - 8192);
	endfunction

	initial begin
		readings_t rd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells at the reset settings.
		send_cell({NUM_SLOTS{13'h1FFF}});
		send_cell({NUM_SLOTS{13'h0000}});
		send_cell({NUM_SLOTS{13'h0FFF}});
		send_cell({NUM_SLOTS{13'h1000}});
		send_cell({NUM_SLOTS{13'h0001}});
		send_cell({13'h0FFF, 13'h1FFF, 13'd0, 13'h1555, 13'd5, 13'h1FFF, 13'd1, 13'h0AAA});
		for (int s = 0; s < NUM_SLOTS; s++) begin
			rd = {NUM_SLOTS{13'h1FFF}};
			rd[s] = 13'd3 + 13'(s);
			send_cell(rd);
		end
		drain();

		// Zero normalizing sum, and a certain prior that saturates.
		write_all(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
		send_cell({NUM_SLOTS{13'h0000}});
		send_cell({13'd0, 13'd7, 13'h1FFF, 13'd0, 13'd1, 13'd0, 13'd2, 13'd0});
		drain();
		write_all(17'hFFFF, 17'hFFFF, 17'd0, 17'h0FFFF, 17'h0FFFF, 17'h10000, 17'h10000);
		send_cell({NUM_SLOTS{13'h0000}});
		send_cell({NUM_SLOTS{13'h0FFF}});
		send_cell({13'd1, 13'd0, 13'h0FFF, 13'd2, 13'h1FFF, 13'd0, 13'd1, 13'd0});
		drain();
		write_all(17'd1, 17'd1, 17'hFFFF, 17'h10000, 17'h10000, 17'h0FFFF, 17'h0FFFF);
		send_random(8);
		drain();

		// Reset settings in the first phase and random settings after, with random
		// cells, one phase without gaps and one with a long output hold-off.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0)
				write_all(17'd32768, 17'd13107, 17'd52429, 17'sd3277, 17'sd32768,
					-17'sd6554, 17'sd19661);
			else
				write_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					rand_slope(), CFG_W'($urandom), rand_slope(), CFG_W'($urandom));
			gaps_on = (ph != 3);
			if (ph == 5) hold_off = 1'b1;
			send_random(200);
			drain();
		end
		gaps_on = 1'b1;

		done = 1'b1;
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
